FILE: sv/ras_pkg.sv
// ----------------------------------------------------------------------------
// ras_pkg
// shared constants, types and register codes of the room allocation scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package ras_pkg;

    // number of rooms held in the ring
    localparam int ROOMS = 64;
    localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    // wide enough for the active room count 1..ROOMS
    localparam int NR_W  = IDX_W + 1;

    localparam int T_W    = 32;   // request time width
    localparam int FREE_W = 48;   // finish time width
    localparam int CNT_W  = 32;   // use count width
    localparam int ROOM_W = 6;    // reported room index width
    localparam int CFG_W  = 7;    // num_rooms register width

    // apb
    localparam int APB_DW = 32;
    localparam int APB_AW = 2;
    localparam logic [APB_AW-1:0] REG_NUM_ROOMS = 2'd0;
    localparam logic [CFG_W-1:0]  NUM_ROOMS_RST = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD
    } t_state;

    // ring control from the sequencer
    typedef struct packed {
        logic              shift;
        logic              clr;
        logic              we;
        logic [IDX_W-1:0]  widx;
        logic [FREE_W-1:0] wfree;
        logic [CNT_W-1:0]  wcnt;
    } t_ring_ctl;

    // per-room data seen at the ring head
    typedef struct packed {
        logic [FREE_W-1:0] free;
        logic [CNT_W-1:0]  cnt;
    } t_head;

    // scan step into the compare unit
    typedef struct packed {
        logic             step;
        logic             first;
        logic             active;
        logic [IDX_W-1:0] idx;
        logic [T_W-1:0]   start;
    } t_scan_ctl;

    // outcome of a full scan
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  ff_idx;
        logic [CNT_W-1:0]  ff_cnt;
        logic [IDX_W-1:0]  min_idx;
        logic [FREE_W-1:0] min_free;
        logic [CNT_W-1:0]  min_cnt;
        logic [IDX_W-1:0]  best_idx;
        logic [CNT_W-1:0]  best_cnt;
    } t_scan_res;

endpackage

`default_nettype wire

FILE: sv/ras_in_if.sv
// ----------------------------------------------------------------------------
// ras_in_if
// request channel: start time, end time and end-of-set flag
// ----------------------------------------------------------------------------
`default_nettype none

interface ras_in_if;
    logic                     valid;
    logic                     ready;
    logic [ras_pkg::T_W-1:0]  start_time;
    logic [ras_pkg::T_W-1:0]  end_time;
    logic                     last;

    modport source (output valid, start_time, end_time, last, input ready);
    modport sink   (input valid, start_time, end_time, last, output ready);
endinterface

`default_nettype wire

FILE: sv/ras_out_if.sv
// ----------------------------------------------------------------------------
// ras_out_if
// result channel: assigned room, times and most-booked room on set close
// ----------------------------------------------------------------------------
`default_nettype none

interface ras_out_if;
    logic                        valid;
    logic                        ready;
    logic [ras_pkg::ROOM_W-1:0]  room;
    logic [ras_pkg::FREE_W-1:0]  begin_time;
    logic [ras_pkg::FREE_W-1:0]  finish_time;
    logic [ras_pkg::ROOM_W-1:0]  most_booked;
    logic                        done_res;

    modport source (output valid, room, begin_time, finish_time, most_booked, done_res,
                    input ready);
    modport sink   (input valid, room, begin_time, finish_time, most_booked, done_res,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/ras_cell.sv
// ----------------------------------------------------------------------------
// ras_cell
// one ring cell: holds finish time and use count of one room
// ----------------------------------------------------------------------------
`default_nettype none

module ras_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_shift,
    input  wire logic           i_clr,
    input  wire logic           i_we,
    input  ras_pkg::t_head      i_wdata,
    input  ras_pkg::t_head      i_nb,
    output ras_pkg::t_head      o_data
);

    ras_pkg::t_head r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_data <= '0;
        end else if (i_we) begin
            r_data <= i_wdata;
        end else if (i_shift) begin
            r_data <= i_nb;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: sv/ras_ring.sv
// ----------------------------------------------------------------------------
// ras_ring
// circular chain of room cells, rotating one place toward the head per shift
// ----------------------------------------------------------------------------
`default_nettype none

module ras_ring (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  ras_pkg::t_ring_ctl  i_ctl,
    output ras_pkg::t_head      o_head
);

    ras_pkg::t_head w_data [ras_pkg::ROOMS];
    ras_pkg::t_head w_wdata;

    assign w_wdata.free = i_ctl.wfree;
    assign w_wdata.cnt  = i_ctl.wcnt;

    for (genvar k = 0; k < ras_pkg::ROOMS; k++) begin : g_cell
        logic w_we;
        assign w_we = i_ctl.we && (i_ctl.widx == ras_pkg::IDX_W'(k));

        ras_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_ctl.shift),
            .i_clr   (i_ctl.clr),
            .i_we    (w_we),
            .i_wdata (w_wdata),
            .i_nb    (w_data[(k + 1) % ras_pkg::ROOMS]),
            .o_data  (w_data[k])
        );
    end

    assign o_head = w_data[0];

endmodule

`default_nettype wire

FILE: sv/ras_scan.sv
// ----------------------------------------------------------------------------
// ras_scan
// shared compare unit: first free room, earliest finish and most used room
// ----------------------------------------------------------------------------
`default_nettype none

module ras_scan (
    input  wire logic           i_clk,
    input  ras_pkg::t_scan_ctl  i_ctl,
    input  ras_pkg::t_head      i_head,
    output ras_pkg::t_scan_res  o_res
);

    ras_pkg::t_scan_res r_res;
    logic w_free_hit;
    logic w_min_hit;
    logic w_best_hit;

    assign w_free_hit = i_ctl.active
                     && (i_head.free <= {{(ras_pkg::FREE_W-ras_pkg::T_W){1'b0}}, i_ctl.start})
                     && (i_ctl.first || !r_res.found);
    assign w_min_hit  = i_ctl.active && (i_ctl.first || (i_head.free < r_res.min_free));
    assign w_best_hit = i_ctl.active && (i_ctl.first || (i_head.cnt > r_res.best_cnt));

    // room 0 is always active, so the first step seeds every tracker
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            if (i_ctl.first) begin
                r_res.found <= w_free_hit;
            end else if (w_free_hit) begin
                r_res.found <= 1'b1;
            end
            if (w_free_hit) begin
                r_res.ff_idx <= i_ctl.idx;
                r_res.ff_cnt <= i_head.cnt;
            end
            if (w_min_hit) begin
                r_res.min_idx  <= i_ctl.idx;
                r_res.min_free <= i_head.free;
                r_res.min_cnt  <= i_head.cnt;
            end
            if (w_best_hit) begin
                r_res.best_idx <= i_ctl.idx;
                r_res.best_cnt <= i_head.cnt;
            end
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: sv/room_allocation_scheduler.sv
// ----------------------------------------------------------------------------
// room_allocation_scheduler
// assigns each request to the lowest free room or the earliest finishing one
// ----------------------------------------------------------------------------
// Each item is taken in the idle state; then the room state, which sits in a
// ring of ROOMS cells, rotates once past a single compare unit, one room per
// cycle, and the update state writes the chosen room back and loads the result
// register. A new item is taken as soon as the previous one has been written
// back, even while its result still waits at the output; a result that still
// waits when the next scan ends holds that write back until the result is
// taken. Rooms at or above the active room count are carried through the ring
// but ignored. Reset clears all room state, and so does an item marked last
// once its result is formed.
// ----------------------------------------------------------------------------
`default_nettype none

module room_allocation_scheduler (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request and result channels
    ras_in_if.sink                           i_req,
    ras_out_if.source                        o_res,
    // apb configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ras_pkg::APB_AW-1:0]  paddr,
    input  wire logic [ras_pkg::APB_DW-1:0]  pwdata,
    output logic      [ras_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [ras_pkg::CFG_W-1:0] r_num_rooms;
    logic [ras_pkg::NR_W-1:0]  w_active_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rooms <= ras_pkg::NUM_ROOMS_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr == ras_pkg::REG_NUM_ROOMS)) begin
            r_num_rooms <= pwdata[ras_pkg::CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ras_pkg::REG_NUM_ROOMS)
                  ? {{(ras_pkg::APB_DW-ras_pkg::CFG_W){1'b0}}, r_num_rooms}
                  : '0;

    // zero rooms acts as one, more than the ring holds acts as all of it
    always_comb begin
        if (r_num_rooms == '0) begin
            w_active_n = ras_pkg::NR_W'(1);
        end else if (32'(r_num_rooms) > ras_pkg::ROOMS) begin
            w_active_n = ras_pkg::NR_W'(ras_pkg::ROOMS);
        end else begin
            w_active_n = ras_pkg::NR_W'(r_num_rooms);
        end
    end

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    ras_pkg::t_state                r_state, n_state;
    logic [ras_pkg::IDX_W-1:0]      r_idx;
    logic [ras_pkg::T_W-1:0]        r_start;
    logic [ras_pkg::T_W-1:0]        r_end;
    logic                           r_last;

    // result register
    logic                           r_ovalid;
    logic [ras_pkg::ROOM_W-1:0]     r_room;
    logic [ras_pkg::FREE_W-1:0]     r_begin;
    logic [ras_pkg::FREE_W-1:0]     r_finish;
    logic [ras_pkg::ROOM_W-1:0]     r_most;
    logic                           r_done;

    ras_pkg::t_ring_ctl  w_ring_ctl;
    ras_pkg::t_head      w_head;
    ras_pkg::t_scan_ctl  w_scan_ctl;
    ras_pkg::t_scan_res  w_scan;

    logic w_in_acc;
    logic w_out_acc;
    logic w_load;       // write back and fill the result register

    // write-back arithmetic
    logic [ras_pkg::T_W-1:0]        w_len;
    logic [ras_pkg::FREE_W:0]       w_sum;
    logic [ras_pkg::IDX_W-1:0]      w_pick;
    logic [ras_pkg::FREE_W-1:0]     w_begin;
    logic [ras_pkg::FREE_W-1:0]     w_finish;
    logic [ras_pkg::CNT_W-1:0]      w_pcnt;
    logic [ras_pkg::CNT_W-1:0]      w_ncnt;
    logic [ras_pkg::IDX_W-1:0]      w_most;

    assign w_in_acc  = i_req.valid && i_req.ready;
    assign w_out_acc = o_res.valid && o_res.ready;

    // ------------------------------------------------------------------
    // room ring and compare unit
    // ------------------------------------------------------------------
    ras_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ring_ctl),
        .o_head  (w_head)
    );

    assign w_scan_ctl.step   = (r_state == ras_pkg::ST_SCAN);
    assign w_scan_ctl.first  = (r_idx == '0);
    assign w_scan_ctl.active = ({1'b0, r_idx} < w_active_n);
    assign w_scan_ctl.idx    = r_idx;
    assign w_scan_ctl.start  = r_start;

    ras_scan u_scan (
        .i_clk  (i_clk),
        .i_ctl  (w_scan_ctl),
        .i_head (w_head),
        .o_res  (w_scan)
    );

    // ------------------------------------------------------------------
    // choice of room and its new state
    // ------------------------------------------------------------------
    assign w_len = r_end - r_start;   // wraps when end is before start
    assign w_sum = {1'b0, w_scan.min_free}
                 + {{(ras_pkg::FREE_W+1-ras_pkg::T_W){1'b0}}, w_len};

    always_comb begin
        if (w_scan.found) begin
            w_pick   = w_scan.ff_idx;
            w_begin  = {{(ras_pkg::FREE_W-ras_pkg::T_W){1'b0}}, r_start};
            w_finish = {{(ras_pkg::FREE_W-ras_pkg::T_W){1'b0}}, r_end};
            w_pcnt   = w_scan.ff_cnt;
        end else begin
            // no room free yet: delay onto the earliest finishing room
            w_pick   = w_scan.min_idx;
            w_begin  = w_scan.min_free;
            w_finish = w_sum[ras_pkg::FREE_W] ? '1 : w_sum[ras_pkg::FREE_W-1:0];
            w_pcnt   = w_scan.min_cnt;
        end
        w_ncnt = (w_pcnt == '1) ? w_pcnt : w_pcnt + ras_pkg::CNT_W'(1);
        // only the picked room's count moved, so it either takes the lead
        // or the old leader stays
        if ((w_ncnt > w_scan.best_cnt)
            || ((w_ncnt == w_scan.best_cnt) && (w_pick < w_scan.best_idx))) begin
            w_most = w_pick;
        end else begin
            w_most = w_scan.best_idx;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ras_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        i_req.ready      = 1'b0;
        w_load           = 1'b0;
        w_ring_ctl.shift = 1'b0;
        w_ring_ctl.clr   = 1'b0;
        w_ring_ctl.we    = 1'b0;
        w_ring_ctl.widx  = w_pick;
        w_ring_ctl.wfree = w_finish;
        w_ring_ctl.wcnt  = w_ncnt;
        case (r_state)
            ras_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = ras_pkg::ST_SCAN;
                end
            end
            ras_pkg::ST_SCAN: begin
                // one full turn brings every room back to its own cell
                w_ring_ctl.shift = 1'b1;
                if (r_idx == ras_pkg::IDX_W'(ras_pkg::ROOMS - 1)) begin
                    n_state = ras_pkg::ST_UPD;
                end
            end
            ras_pkg::ST_UPD: begin
                if (!r_ovalid || o_res.ready) begin
                    w_load         = 1'b1;
                    w_ring_ctl.we  = !r_last;
                    w_ring_ctl.clr = r_last;
                    n_state        = ras_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ras_pkg::ST_IDLE;
            end
        endcase
    end

    // request capture and room counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_in_acc) begin
            r_idx <= '0;
        end else if (r_state == ras_pkg::ST_SCAN) begin
            r_idx <= r_idx + ras_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_start <= i_req.start_time;
            r_end   <= i_req.end_time;
            r_last  <= i_req.last;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (w_out_acc) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_room   <= ras_pkg::ROOM_W'(w_pick);
            r_begin  <= w_begin;
            r_finish <= w_finish;
            r_most   <= r_last ? ras_pkg::ROOM_W'(w_most) : '0;
            r_done   <= r_last;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.room        = r_room;
    assign o_res.begin_time  = r_begin;
    assign o_res.finish_time = r_finish;
    assign o_res.most_booked = r_most;
    assign o_res.done_res    = r_done;

endmodule

`default_nettype wire

FILE: verif/ras_booking_check.sv
// ----------------------------------------------------------------------------
// ras_booking_check
// watches the request, result and apb ports and checks every booking result
// ----------------------------------------------------------------------------
// keeps its own copy of the room state and of num_rooms, works out the
// booking for every accepted request and compares each accepted result
// against the oldest booking still due
// ----------------------------------------------------------------------------
`default_nettype none

module ras_booking_check
    import ras_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ras_in_if                      i_req,
    ras_out_if                     i_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ROOM_W-1:0] room;
        logic [FREE_W-1:0] begin_t;
        logic [FREE_W-1:0] finish_t;
        logic [ROOM_W-1:0] most;
        logic              done;
    } t_booking;

    logic [FREE_W-1:0] free_at [ROOMS];
    logic [CNT_W-1:0]  uses    [ROOMS];
    logic [CFG_W-1:0]  rooms_cfg = NUM_ROOMS_RST;
    t_booking          bookings_due [$];
    int                fails   = 0;
    int                waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    function automatic void clear_rooms();
        int i;
        for (i = 0; i < ROOMS; i++) begin
            free_at[i] = '0;
            uses[i]    = '0;
        end
    endfunction

    // lowest free room, else earliest finishing room with the request delayed
    function automatic t_booking book_request(logic [T_W-1:0] s, logic [T_W-1:0] e, logic l);
        t_booking        b;
        int              n;
        int              i;
        int              pick;
        int              best;
        logic            found;
        logic [FREE_W:0] len_w;
        logic [FREE_W:0] sum;
        n = (rooms_cfg == 0) ? 1 : ((rooms_cfg > ROOMS) ? ROOMS : int'(rooms_cfg));
        found = 1'b0;
        pick  = 0;
        for (i = 0; i < n; i++) begin
            if (!found && free_at[i] <= FREE_W'(s)) begin
                pick  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            b.begin_t  = FREE_W'(s);
            b.finish_t = FREE_W'(e);
        end else begin
            len_w = '0;
            len_w[T_W-1:0] = e - s;
            pick = 0;
            for (i = 1; i < n; i++) begin
                if (free_at[i] < free_at[pick])
                    pick = i;
            end
            b.begin_t  = free_at[pick];
            sum        = {1'b0, free_at[pick]} + len_w;
            b.finish_t = sum[FREE_W] ? {FREE_W{1'b1}} : sum[FREE_W-1:0];
        end
        free_at[pick] = b.finish_t;
        if (uses[pick] != {CNT_W{1'b1}})
            uses[pick] = uses[pick] + 1'b1;
        b.room = ROOM_W'(pick);
        b.most = '0;
        b.done = l;
        if (l) begin
            best = 0;
            for (i = 1; i < n; i++) begin
                if (uses[i] > uses[best])
                    best = i;
            end
            b.most = ROOM_W'(best);
            clear_rooms();
        end
        return b;
    endfunction

    function automatic void check_field(string what, logic [FREE_W-1:0] want,
                                        logic [FREE_W-1:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_booking exp_b;
        if (!i_rst_n) begin
            clear_rooms();
            rooms_cfg = NUM_ROOMS_RST;
            bookings_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (bookings_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got room %0d", $time,
                             i_res.room);
                end else begin
                    exp_b = bookings_due.pop_front();
                    check_field("room", FREE_W'(exp_b.room), FREE_W'(i_res.room));
                    check_field("begin_time", exp_b.begin_t, i_res.begin_time);
                    check_field("finish_time", exp_b.finish_t, i_res.finish_time);
                    check_field("most_booked", FREE_W'(exp_b.most), FREE_W'(i_res.most_booked));
                    check_field("done_res", FREE_W'(exp_b.done), FREE_W'(i_res.done_res));
                end
            end
            if (i_req.valid && i_req.ready)
                bookings_due.push_back(book_request(i_req.start_time, i_req.end_time,
                                                    i_req.last));
            if (psel && penable && pwrite && pready && paddr == REG_NUM_ROOMS)
                rooms_cfg = pwdata[CFG_W-1:0];
        end
        waiting = bookings_due.size();
    end

endmodule

`default_nettype wire

FILE: verif/tb_room_allocation_scheduler.sv
// ----------------------------------------------------------------------------
// tb_room_allocation_scheduler
// stimulus and verdict for the room allocation scheduler
// ----------------------------------------------------------------------------
// a directed run over the room count extremes, delayed and free bookings,
// end-not-after-start requests and unsorted starts, then random booking sets
// with random handshake gaps on both sides; results are checked beside the
// block by ras_booking_check
// ----------------------------------------------------------------------------
`default_nettype none

module tb_room_allocation_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import ras_pkg::*;

    localparam int N_ITEMS   = 900;
    localparam int LIMIT     = 400_000;   // cycles before the run is called hung
    localparam int LONG_HOLD = 800;       // long receiver hold-off, in cycles

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int   n_sent   = 0;    // requests accepted by the block
    int   n_got    = 0;    // results taken from the block
    logic tx_calm  = 1'b0; // sender runs without gaps
    logic rx_calm  = 1'b0; // receiver runs without stalls
    logic hold_req = 1'b0; // ask the receiver for one long hold-off
    int   fail_count;
    int   pending;

    ras_in_if  req_if ();
    ras_out_if res_if ();

    room_allocation_scheduler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ras_booking_check booking_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hang guard
    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // cycles to wait before the next item or result, none while calm
    function automatic int draw_gap(logic calm);
        return calm ? 0 : int'($urandom_range(0, 11));
    endfunction

    // offer one request and hold it until the block takes it; valid is only
    // lowered when a gap follows, so it never drops and rises in one step
    task automatic send_req(input logic [T_W-1:0] s, input logic [T_W-1:0] e,
                            input logic l);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.start_time <= s;
        req_if.end_time   <= e;
        req_if.last       <= l;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        n_sent++;
    endtask

    // stop offering and wait until every result is back, then let the
    // block settle
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (n_got != n_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // num_rooms is only written while the block is idle
    task automatic set_rooms(input logic [CFG_W-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_NUM_ROOMS;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one booking set: mostly nondecreasing starts with random lengths, a
    // little noise and some ends not after their starts, last on the final item
    task automatic run_set(input int size, input int step_max);
        logic [T_W-1:0] t;
        logic [T_W-1:0] s;
        logic [T_W-1:0] e;
        int unsigned    span;
        int             step;
        int             kind;
        int             k;
        t    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
        step = $urandom_range(0, step_max);
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(1 << 20, 32'hFFFF_FFFF)
                                            : $urandom_range(1, 400);
        tx_calm = ($urandom_range(0, 3) == 0);
        for (k = 0; k < size; k++) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                // noise: unsorted start, any end
                s = $urandom;
                e = $urandom;
            end else if (kind == 1) begin
                // end at or just below start
                s = t;
                e = t - T_W'($urandom_range(0, 3));
            end else begin
                t = t + T_W'($urandom_range(0, step));
                s = t;
                e = t + T_W'($urandom_range(1, span));
            end
            send_req(s, e, k == size - 1);
        end
    endtask

    // result side: random stalls, calm stretches, one long hold-off
    initial begin : result_sink
        int   stall;
        logic held;
        held = 1'b0;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (n_got % 40 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            stall = draw_gap(rx_calm);
            // the block fills up and stalls its input while this lasts
            if (hold_req && !held) begin
                stall = LONG_HOLD;
                held  = 1'b1;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            n_got++;
        end
    end

    initial begin : stimulus
        int size;
        logic [CFG_W-1:0] rooms;
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.start_time <= '0;
        req_if.end_time   <= '0;
        req_if.last       <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all rooms at the reset count: equal starts spread over rooms, a free
        // time equal to the start counts as free, an end equal to its start
        send_req(32'd0, 32'd10, 1'b0);
        send_req(32'd0, 32'd10, 1'b0);
        send_req(32'd10, 32'd20, 1'b0);
        send_req(32'd5, 32'd5, 1'b0);
        send_req(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1);

        // a single room: delays, free booking that ends before its start,
        // a wrapping length and a delayed begin beyond 32 bits
        set_rooms(7'd1);
        send_req(32'd0, 32'd100, 1'b0);
        send_req(32'd50, 32'd60, 1'b0);
        send_req(32'd200, 32'd150, 1'b0);
        send_req(32'd160, 32'd159, 1'b0);
        send_req(32'd100, 32'd99, 1'b0);
        send_req(32'd0, 32'hFFFF_FFFF, 1'b1);

        // zero rooms behave as one; start order broken on the last item
        set_rooms(7'd0);
        send_req(32'd7, 32'd9, 1'b0);
        send_req(32'd8, 32'd9, 1'b0);
        send_req(32'd3, 32'd4, 1'b1);

        // count above the room total is capped
        set_rooms(7'd127);
        send_req(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_req(32'd0, 32'd1, 1'b1);

        // three rooms: earliest finish with ties, a zero-length delay and a
        // most-booked room other than room zero
        set_rooms(7'd3);
        send_req(32'd0, 32'd5, 1'b0);
        send_req(32'd0, 32'd6, 1'b0);
        send_req(32'd0, 32'd4, 1'b0);
        send_req(32'd1, 32'd2, 1'b0);
        send_req(32'd1, 32'd3, 1'b0);
        send_req(32'd2, 32'd2, 1'b1);

        // long receiver hold-off while a full room set keeps coming
        set_rooms(7'd64);
        hold_req = 1'b1;
        run_set(40, 2);

        while (n_sent < N_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 15))
                    0:       rooms = 7'd0;
                    1:       rooms = 7'd127;
                    2:       rooms = 7'd64;
                    3:       rooms = CFG_W'($urandom_range(65, 127));
                    4, 5:    rooms = CFG_W'($urandom_range(9, 63));
                    default: rooms = CFG_W'($urandom_range(1, 8));
                endcase
                set_rooms(rooms);
            end else if ($urandom_range(0, 5) == 0) begin
                // sender pause until every result is back
                drain();
            end
            // now and then a long, dense set so that even many rooms run full
            if ($urandom_range(0, 11) == 0) begin
                size = $urandom_range(66, 90);
                run_set(size, 2);
            end else begin
                size = $urandom_range(1, 24);
                run_set(size, 40);
            end
        end

        drain();
        repeat (ROOMS + 20) @(posedge i_clk);
        if (pending != 0)
            $display("%0t: %0d results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
sv/ras_pkg.sv
sv/ras_in_if.sv
sv/ras_out_if.sv
sv/ras_cell.sv
sv/ras_ring.sv
sv/ras_scan.sv
sv/room_allocation_scheduler.sv
verif/ras_booking_check.sv
verif/tb_room_allocation_scheduler.sv
